// ===== rtl/core/vsa_pkg.sv =====
// Shared types and constants for the voice allocator with stealing.
package vsa_pkg;

  localparam int unsigned IdxW  = 5;
  localparam int unsigned StatW = 2;
  localparam int unsigned KeyW  = 16;
  localparam int unsigned PrioW = 8;
  localparam int unsigned AgeW  = 16;

  localparam logic [IdxW-1:0]  VoicesReset = 5'd24;
  localparam logic [KeyW-1:0]  KeyInit     = 16'hFFFF;
  localparam logic [StatW-1:0] StatFree    = 2'd0;
  localparam logic [StatW-1:0] StatKeyOff  = 2'd2;
  localparam logic             CmdAlloc    = 1'b0;
  localparam logic             CmdWrite    = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } vsa_state_e;

  // Running search result handed from one cell to the next.
  typedef struct packed {
    logic             found;
    logic             have;
    logic [PrioW-1:0] thr;
    logic [KeyW-1:0]  best_key;
    logic [AgeW-1:0]  best_age;
    logic [IdxW-1:0]  cand;
    logic             koff;
  } vsa_scan_t;

  // Per-cell update controls from the sequencer.
  typedef struct packed {
    logic active;
    logic wr_hit;
    logic commit;
    logic chosen_hit;
  } vsa_ctl_t;

endpackage

// ===== rtl/core/vsa_cell.sv =====
// One voice cell: holds a voice's state and advances the search by one voice.
module vsa_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [vsa_pkg::IdxW-1:0]      cell_idx_i,
  input  vsa_pkg::vsa_ctl_t             ctl_i,
  input  logic [vsa_pkg::StatW-1:0]     wr_status_i,
  input  logic [vsa_pkg::KeyW-1:0]      wr_key_i,
  input  logic [vsa_pkg::PrioW-1:0]     prio_i,
  input  vsa_pkg::vsa_scan_t            scan_i,
  output vsa_pkg::vsa_scan_t            scan_o
);

  logic [vsa_pkg::StatW-1:0] status_q;
  logic [vsa_pkg::KeyW-1:0]  key_q;
  logic [vsa_pkg::PrioW-1:0] prio_q;
  logic [vsa_pkg::AgeW-1:0]  age_q;
  vsa_pkg::vsa_scan_t        scan_d, scan_q;

  always_comb begin
    scan_d = scan_i;
    if (ctl_i.active && !scan_i.found) begin
      if (status_q == vsa_pkg::StatFree && key_q == '0) begin
        scan_d.found = 1'b1;
        scan_d.cand  = cell_idx_i;
        scan_d.koff  = 1'b0;
      end else if (prio_q < scan_i.thr) begin
        scan_d.thr      = prio_q;
        scan_d.cand     = cell_idx_i;
        scan_d.best_key = key_q;
        scan_d.best_age = age_q;
        scan_d.have     = 1'b1;
        scan_d.koff     = (status_q == vsa_pkg::StatKeyOff);
      end else if (prio_q == scan_i.thr) begin
        if (key_q < scan_i.best_key) begin
          scan_d.cand     = cell_idx_i;
          scan_d.best_key = key_q;
          scan_d.best_age = age_q;
          scan_d.have     = 1'b1;
          scan_d.koff     = (status_q == vsa_pkg::StatKeyOff);
        end else if (key_q == scan_i.best_key && !age_q[vsa_pkg::AgeW-1]
                     && scan_i.best_age < age_q) begin
          scan_d.cand     = cell_idx_i;
          scan_d.best_age = age_q;
          scan_d.have     = 1'b1;
          scan_d.koff     = (status_q == vsa_pkg::StatKeyOff);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
  end

  assign scan_o = scan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      key_q    <= '0;
      prio_q   <= '0;
      age_q    <= '0;
    end else begin
      if (ctl_i.wr_hit) begin
        status_q <= wr_status_i;
        key_q    <= wr_key_i;
        prio_q   <= prio_i;
      end
      if (ctl_i.commit && ctl_i.active) begin
        if (ctl_i.chosen_hit) begin
          age_q  <= '0;
          prio_q <= prio_i;
        end else begin
          age_q <= age_q + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/voice_steal_allocator.sv =====
// Top level of the voice allocator with stealing: sequencer and row of voice cells.
// An item on the input channel is either a write of one voice's status, key and
// priority (cmd 1) or an allocation request for a note of given priority (cmd 0).
// Each item yields exactly one result item on the output channel; a write gives
// an all-zero result. An allocation passes a search record down the row of
// MAX_VOICES cells, one cell per cycle, while the sequencer stays in its scan
// state; a write goes straight from idle to the finish state, which loads the
// result into the output register.
// One item is in work at a time; the next one is accepted once the sequencer is
// back in its idle state, even while the previous result still waits in the
// output register.
// When the receiver stalls, the finished item holds in the sequencer until the
// output register frees up, and no state update happens before that.
// The voices_in_use register is written through cfg_we_i and cfg_wdata_i at
// any edge and must only change while the block is idle.
// Reset clears every voice to free with zero key, priority and age, sets
// voices_in_use to 24 and empties the output register.
module voice_steal_allocator #(
  parameter int unsigned MAX_VOICES = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vsa_pkg::IdxW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [vsa_pkg::PrioW-1:0]     note_priority_i,
  input  logic [vsa_pkg::IdxW-1:0]      voice_index_i,
  input  logic [vsa_pkg::StatW-1:0]     voice_status_i,
  input  logic [vsa_pkg::KeyW-1:0]      voice_key_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vsa_pkg::IdxW-1:0]      chosen_voice_o,
  output logic                          got_voice_o,
  output logic                          key_off_request_o
);

  localparam int unsigned CntW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

  vsa_pkg::vsa_state_e       state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [vsa_pkg::IdxW-1:0]  voices_q;
  logic [vsa_pkg::PrioW-1:0] prio_q;
  logic                      is_wr_q;
  logic                      out_valid_q, out_valid_d;
  logic [vsa_pkg::IdxW-1:0]  chosen_q, chosen_d;
  logic                      got_q, got_d;
  logic                      koff_q, koff_d;

  logic                      in_acc;
  logic                      out_free;
  logic                      wr_now;
  logic                      commit;
  logic                      found_any;
  logic [vsa_pkg::PrioW-1:0] cell_prio;

  vsa_pkg::vsa_scan_t        chain [MAX_VOICES+1];
  vsa_pkg::vsa_scan_t        rec;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign rec      = chain[MAX_VOICES];
  assign found_any = rec.found || rec.have;

  always_comb begin
    chain[0]          = '0;
    chain[0].thr      = prio_q;
    chain[0].best_key = vsa_pkg::KeyInit;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      vsa_pkg::StIdle: begin
        if (in_acc) begin
          if (cmd_i == vsa_pkg::CmdWrite) begin
            state_d = vsa_pkg::StFinish;
          end else begin
            state_d = vsa_pkg::StScan;
            cnt_d   = CntW'(MAX_VOICES - 1);
          end
        end
      end
      vsa_pkg::StScan: begin
        if (cnt_q == '0) begin
          state_d = vsa_pkg::StFinish;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      vsa_pkg::StFinish: begin
        if (out_free) begin
          state_d = vsa_pkg::StIdle;
        end
      end
      default: begin
        state_d = vsa_pkg::StIdle;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o  = 1'b0;
    wr_now      = 1'b0;
    commit      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    chosen_d    = chosen_q;
    got_d       = got_q;
    koff_d      = koff_q;
    case (state_q)
      vsa_pkg::StIdle: begin
        in_ready_o = 1'b1;
        wr_now     = in_valid_i && (cmd_i == vsa_pkg::CmdWrite);
      end
      vsa_pkg::StScan: begin
      end
      vsa_pkg::StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (is_wr_q) begin
            chosen_d = '0;
            got_d    = 1'b0;
            koff_d   = 1'b0;
          end else begin
            commit   = found_any;
            chosen_d = found_any ? rec.cand : voices_q;
            got_d    = found_any;
            koff_d   = found_any && rec.koff;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign cell_prio = wr_now ? note_priority_i : prio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vsa_pkg::StIdle;
      cnt_q       <= '0;
      voices_q    <= vsa_pkg::VoicesReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        voices_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prio_q  <= note_priority_i;
      is_wr_q <= (cmd_i == vsa_pkg::CmdWrite);
    end
    chosen_q <= chosen_d;
    got_q    <= got_d;
    koff_q   <= koff_d;
  end

  for (genvar i = 0; i < MAX_VOICES; i++) begin : g_cell
    vsa_pkg::vsa_ctl_t ctl;

    always_comb begin
      ctl.active     = 32'(voices_q) > i;
      ctl.wr_hit     = wr_now && (32'(voice_index_i) == i);
      ctl.commit     = commit;
      ctl.chosen_hit = (32'(rec.cand) == i);
    end

    vsa_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (vsa_pkg::IdxW'(i)),
      .ctl_i       (ctl),
      .wr_status_i (voice_status_i),
      .wr_key_i    (voice_key_i),
      .prio_i      (cell_prio),
      .scan_i      (chain[i]),
      .scan_o      (chain[i+1])
    );
  end

  assign out_valid_o       = out_valid_q;
  assign chosen_voice_o    = chosen_q;
  assign got_voice_o       = got_q;
  assign key_off_request_o = koff_q;

endmodule

// ===== tb/tb_voice_steal_allocator.sv =====
// Self-checking testbench for the voice allocator with stealing, with its own voice model.
`timescale 1ns / 100ps

module tb_voice_steal_allocator;

  localparam int NumVoices = 24;
  localparam int WatchdogLimit = 3000;
  localparam logic [vsa_pkg::StatW-1:0] StatPlaying = 2'd1;
  localparam logic [vsa_pkg::StatW-1:0] StatReserved = 2'd3;

  typedef struct packed {
    logic                      cmd;
    logic [vsa_pkg::PrioW-1:0] prio;
    logic [vsa_pkg::IdxW-1:0]  idx;
    logic [vsa_pkg::StatW-1:0] stat;
    logic [vsa_pkg::KeyW-1:0]  key;
  } voice_cmd_t;

  typedef struct packed {
    logic [vsa_pkg::IdxW-1:0] chosen;
    logic                     got;
    logic                     koff;
  } voice_grant_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [vsa_pkg::IdxW-1:0]  cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic                      cmd_i = vsa_pkg::CmdAlloc;
  logic [vsa_pkg::PrioW-1:0] note_priority_i = '0;
  logic [vsa_pkg::IdxW-1:0]  voice_index_i = '0;
  logic [vsa_pkg::StatW-1:0] voice_status_i = vsa_pkg::StatFree;
  logic [vsa_pkg::KeyW-1:0]  voice_key_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [vsa_pkg::IdxW-1:0]  chosen_voice_o;
  logic                      got_voice_o;
  logic                      key_off_request_o;

  logic [vsa_pkg::StatW-1:0] voice_stat_q [NumVoices];
  logic [vsa_pkg::KeyW-1:0]  voice_key_q  [NumVoices];
  logic [vsa_pkg::PrioW-1:0] voice_prio_q [NumVoices];
  logic [vsa_pkg::AgeW-1:0]  voice_age_q  [NumVoices];
  logic [vsa_pkg::IdxW-1:0]  voices_cfg = vsa_pkg::VoicesReset;

  voice_cmd_t   pending_items [$];
  voice_grant_t expected_grants [$];
  voice_cmd_t   cur_item;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           items_left = 0;
  int           mismatch_count = 0;
  int           idle_cycles = 0;

  voice_steal_allocator #(
    .MAX_VOICES(NumVoices)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .note_priority_i  (note_priority_i),
    .voice_index_i    (voice_index_i),
    .voice_status_i   (voice_status_i),
    .voice_key_i      (voice_key_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .chosen_voice_o   (chosen_voice_o),
    .got_voice_o      (got_voice_o),
    .key_off_request_o(key_off_request_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic voice_grant_t predict_grant(voice_cmd_t it);
    voice_grant_t              g;
    int                        n;
    logic [vsa_pkg::PrioW-1:0] thr;
    logic [vsa_pkg::KeyW-1:0]  best_key;
    int                        best_age;
    int                        pick;
    logic                      hit;
    logic                      have;
    g = '0;
    if (it.cmd == vsa_pkg::CmdWrite) begin
      if (it.idx < NumVoices) begin
        voice_stat_q[it.idx] = it.stat;
        voice_key_q[it.idx] = it.key;
        voice_prio_q[it.idx] = it.prio;
      end
      return g;
    end
    n = (int'(voices_cfg) > NumVoices) ? NumVoices : int'(voices_cfg);
    thr = it.prio;
    best_key = vsa_pkg::KeyInit;
    best_age = 0;
    pick = 0;
    hit = 1'b0;
    have = 1'b0;
    for (int v = 0; v < n; v++) begin
      if (!hit) begin
        if (voice_stat_q[v] == vsa_pkg::StatFree && voice_key_q[v] == '0) begin
          pick = v;
          hit = 1'b1;
        end else if (voice_prio_q[v] < thr) begin
          thr = voice_prio_q[v];
          pick = v;
          best_key = voice_key_q[v];
          best_age = int'(voice_age_q[v]);
          have = 1'b1;
        end else if (voice_prio_q[v] == thr) begin
          if (voice_key_q[v] < best_key) begin
            best_key = voice_key_q[v];
            best_age = int'(voice_age_q[v]);
            pick = v;
            have = 1'b1;
          end else if (voice_key_q[v] == best_key &&
                       best_age < int'($signed(voice_age_q[v]))) begin
            best_age = int'(voice_age_q[v]);
            pick = v;
            have = 1'b1;
          end
        end
      end
    end
    if (!hit && !have) begin
      g.chosen = voices_cfg;
      return g;
    end
    for (int v = 0; v < n; v++) begin
      voice_age_q[v] = voice_age_q[v] + 1'b1;
    end
    voice_age_q[pick] = '0;
    voice_prio_q[pick] = it.prio;
    g.chosen = pick[vsa_pkg::IdxW-1:0];
    g.got = 1'b1;
    g.koff = (voice_stat_q[pick] == vsa_pkg::StatKeyOff);
    return g;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_grants.push_back(predict_grant(cur_item));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= cur_item.cmd;
          note_priority_i <= cur_item.prio;
          voice_index_i <= cur_item.idx;
          voice_status_i <= cur_item.stat;
          voice_key_i <= cur_item.key;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    voice_grant_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected item, chosen_voice %0d got_voice %0d key_off_request %0d",
                   $time, chosen_voice_o, got_voice_o, key_off_request_o);
          mismatch_count++;
        end else begin
          want = expected_grants.pop_front();
          if (chosen_voice_o !== want.chosen) begin
            $display("%0t: chosen_voice expected %0d actual %0d",
                     $time, want.chosen, chosen_voice_o);
            mismatch_count++;
          end
          if (got_voice_o !== want.got) begin
            $display("%0t: got_voice expected %0d actual %0d", $time, want.got, got_voice_o);
            mismatch_count++;
          end
          if (key_off_request_o !== want.koff) begin
            $display("%0t: key_off_request expected %0d actual %0d",
                     $time, want.koff, key_off_request_o);
            mismatch_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("voice_steal_allocator test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_grants.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic set_voices(input int n);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n[vsa_pkg::IdxW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    voices_cfg = n[vsa_pkg::IdxW-1:0];
  endtask

  task automatic push_write(input int idx, input logic [vsa_pkg::StatW-1:0] st,
                            input logic [vsa_pkg::KeyW-1:0] k,
                            input logic [vsa_pkg::PrioW-1:0] p);
    voice_cmd_t it;
    it.cmd = vsa_pkg::CmdWrite;
    it.idx = idx[vsa_pkg::IdxW-1:0];
    it.stat = st;
    it.key = k;
    it.prio = p;
    pending_items.push_back(it);
    if (idx < NumVoices) items_left--;
  endtask

  task automatic push_alloc(input logic [vsa_pkg::PrioW-1:0] p);
    voice_cmd_t it;
    it.cmd = vsa_pkg::CmdAlloc;
    it.prio = p;
    it.idx = vsa_pkg::IdxW'($urandom_range(31));
    it.stat = vsa_pkg::StatW'($urandom_range(3));
    it.key = vsa_pkg::KeyW'($urandom);
    pending_items.push_back(it);
    items_left--;
  endtask

  function automatic logic [vsa_pkg::KeyW-1:0] rand_key();
    logic [vsa_pkg::KeyW-1:0] k;
    case ($urandom_range(3))
      0: k = '0;
      1: k = vsa_pkg::KeyInit;
      2: k = vsa_pkg::KeyW'($urandom_range(3));
      default: k = vsa_pkg::KeyW'($urandom);
    endcase
    return k;
  endfunction

  function automatic logic [vsa_pkg::PrioW-1:0] rand_prio();
    logic [vsa_pkg::PrioW-1:0] p;
    case ($urandom_range(3))
      0: p = vsa_pkg::PrioW'($urandom_range(3));
      1: p = '1;
      2: p = vsa_pkg::PrioW'($urandom_range(8, 11));
      default: p = vsa_pkg::PrioW'($urandom_range(255));
    endcase
    return p;
  endfunction

  function automatic logic [vsa_pkg::StatW-1:0] rand_busy_status();
    logic [vsa_pkg::StatW-1:0] s;
    if ($urandom_range(9) == 0) s = vsa_pkg::StatFree;
    else s = vsa_pkg::StatW'($urandom_range(StatPlaying, StatReserved));
    return s;
  endfunction

  initial begin
    int nv;
    int r;
    for (int v = 0; v < NumVoices; v++) begin
      voice_stat_q[v] = vsa_pkg::StatFree;
      voice_key_q[v] = '0;
      voice_prio_q[v] = '0;
      voice_age_q[v] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: free search, stealing with key-off, ignored writes, no candidate,
    // the tie that never beats the initial key and age, and the extremes of the count.
    send_idle_pct = 9;
    recv_idle_pct = 64;
    push_alloc(8'd0);
    push_write(0, vsa_pkg::StatKeyOff, 16'h0000, 8'd5);
    push_write(1, StatPlaying, vsa_pkg::KeyInit, 8'd255);
    push_write(2, StatReserved, 16'h0001, 8'd5);
    push_write(31, StatReserved, vsa_pkg::KeyInit, 8'd255);
    push_write(24, vsa_pkg::StatFree, 16'h0000, 8'd0);
    push_write(3, vsa_pkg::StatFree, 16'h8000, 8'd200);
    push_alloc(8'd255);
    set_voices(3);
    push_alloc(8'd255);
    push_alloc(8'd4);
    push_alloc(8'd5);
    set_voices(1);
    push_write(0, StatPlaying, 16'h0005, 8'd0);
    push_alloc(8'd9);
    push_write(0, StatPlaying, vsa_pkg::KeyInit, 8'd9);
    push_alloc(8'd9);
    push_alloc(8'd255);
    set_voices(0);
    push_alloc(8'd128);
    set_voices(31);
    push_alloc(8'd255);
    push_write(23, vsa_pkg::StatKeyOff, vsa_pkg::KeyInit, 8'd0);
    push_alloc(8'd0);
    set_voices(24);
    push_alloc(8'd1);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 9 : (mode == 1) ? 64 : 0;
      recv_idle_pct = (mode == 0) ? 64 : (mode == 1) ? 9 : 0;
      items_left = 500;
      while (items_left > 0) begin
        r = int'($urandom_range(9));
        nv = (r == 0) ? 0 : (r == 1) ? int'($urandom_range(25, 31)) : (r == 2) ? NumVoices :
             (r == 3) ? 1 : int'($urandom_range(1, NumVoices));
        set_voices(nv);
        if ($urandom_range(9) < 7) begin
          for (int v = 0; v < NumVoices && v < nv; v++) begin
            push_write(v, rand_busy_status(), rand_key(), rand_prio());
          end
        end
        repeat ($urandom_range(10, 30)) begin
          r = int'($urandom_range(9));
          if (r < 7) begin
            push_alloc(rand_prio());
          end else if (r < 9) begin
            push_write(int'($urandom_range(NumVoices - 1)), rand_busy_status(), rand_key(),
                       rand_prio());
          end else begin
            push_write(int'($urandom_range(31)), vsa_pkg::StatW'($urandom_range(3)),
                       vsa_pkg::KeyW'($urandom), vsa_pkg::PrioW'($urandom_range(255)));
          end
        end
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && expected_grants.size() == 0) begin
      $display("voice_steal_allocator test passed");
    end else begin
      $display("voice_steal_allocator test failed");
    end
    $finish;
  end

endmodule
